// ===== src/dtsb_pkg.sv =====
// Shared constants, codes and types of the depth-tested sample buffer.
// No dependencies; every other file refers to this package by scoped names.
package dtsb_pkg;

   localparam int MAX_SAMPLE_WIDTH  = 256;
   localparam int MAX_SAMPLE_HEIGHT = 256;
   localparam int ADDR_W  = $clog2(MAX_SAMPLE_WIDTH * MAX_SAMPLE_HEIGHT);
   localparam int CLR_W   = $clog2(MAX_SAMPLE_WIDTH * MAX_SAMPLE_HEIGHT + 1);
   localparam int SW_W    = $clog2(MAX_SAMPLE_WIDTH + 1);
   localparam int SH_W    = $clog2(MAX_SAMPLE_HEIGHT + 1);
   localparam int COL_W   = $clog2(MAX_SAMPLE_WIDTH);
   localparam int ROW_W   = $clog2(MAX_SAMPLE_HEIGHT);
   localparam int BOX_W   = 10;
   localparam int CNT_W   = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W = 4;

   localparam logic [23:0]      DEPTH_ONE = 24'd256;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ANTIALIAS    = 2'd2;
   localparam logic [1:0] REG_BACKGROUND   = 2'd3;

   typedef enum logic [1:0] {
      MODE_CLEAR      = 2'd0,
      MODE_FRAGMENT   = 2'd1,
      MODE_RESOLVE    = 2'd2,
      MODE_READ_DIRTY = 2'd3
   } mode_type;

   typedef struct packed {
      logic [2:0]      aa;
      logic [SW_W-1:0] sw;
      logic [SH_W-1:0] sh;
   } grid_type;

   typedef struct packed {
      mode_type         mode;
      logic             ok;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [23:0]      depth;
      logic [23:0]      color;
      grid_type         grid;
   } entry_type;

endpackage

// ===== src/dtsb_if.sv =====
// Request and response channel interfaces of the sample buffer.
// Depends on dtsb_pkg for field widths.
interface dtsb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [12:0] coord_x;
   logic signed [12:0] coord_y;
   logic [23:0]        depth;
   logic [7:0]         red_in;
   logic [7:0]         green_in;
   logic [7:0]         blue_in;
   modport source (output valid, mode, coord_x, coord_y, depth, red_in, green_in, blue_in,
                   input ready);
   modport sink   (input valid, mode, coord_x, coord_y, depth, red_in, green_in, blue_in,
                   output ready);
endinterface

interface dtsb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [7:0]                          red_out;
   logic [7:0]                          green_out;
   logic [7:0]                          blue_out;
   logic                                accepted;
   logic signed [dtsb_pkg::BOX_W-1:0]   box_left;
   logic signed [dtsb_pkg::BOX_W-1:0]   box_right;
   logic signed [dtsb_pkg::BOX_W-1:0]   box_down;
   logic signed [dtsb_pkg::BOX_W-1:0]   box_up;
   logic [dtsb_pkg::CNT_W-1:0]          changed_count;
   modport source (output valid, red_out, green_out, blue_out, accepted, box_left, box_right,
                   box_down, box_up, changed_count, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, accepted, box_left, box_right,
                   box_down, box_up, changed_count, output ready);
endinterface

// ===== src/dtsb_front.sv =====
// Front end: takes request transactions and classifies them into queue entries.
// Depends on dtsb_pkg and dtsb_if.
module dtsb_front (
   dtsb_req_if.sink              req_chan,
   input  dtsb_pkg::grid_type    grid,
   input  logic                  q_full,
   output logic                  push,
   output dtsb_pkg::entry_type   push_entry
);
   logic [12:0] cx_u, cy_u;
   logic [15:0] end_x, end_y, base_x, base_y;
   logic        nonneg, frag_ok, res_ok;

   always_comb begin
      cx_u   = req_chan.coord_x;
      cy_u   = req_chan.coord_y;
      nonneg = !cx_u[12] && !cy_u[12];
      base_x = 16'(cx_u) * 16'(grid.aa);
      base_y = 16'(cy_u) * 16'(grid.aa);
      end_x  = 16'(cx_u + 13'd1) * 16'(grid.aa);
      end_y  = 16'(cy_u + 13'd1) * 16'(grid.aa);
      frag_ok = nonneg && (cx_u < 13'(grid.sw)) && (cy_u < 13'(grid.sh))
                && (req_chan.depth > dtsb_pkg::DEPTH_ONE);
      res_ok  = nonneg && (end_x <= 16'(grid.sw)) && (end_y <= 16'(grid.sh));
   end

   always_comb begin
      push_entry.mode  = dtsb_pkg::mode_type'(req_chan.mode);
      push_entry.depth = req_chan.depth;
      push_entry.color = {req_chan.red_in, req_chan.green_in, req_chan.blue_in};
      push_entry.grid  = grid;
      unique case (dtsb_pkg::mode_type'(req_chan.mode))
         dtsb_pkg::MODE_FRAGMENT: begin
            push_entry.ok  = frag_ok;
            push_entry.row = cy_u[dtsb_pkg::ROW_W-1:0];
            push_entry.col = cx_u[dtsb_pkg::COL_W-1:0];
         end
         dtsb_pkg::MODE_RESOLVE: begin
            push_entry.ok  = res_ok;
            push_entry.row = base_y[dtsb_pkg::ROW_W-1:0];
            push_entry.col = base_x[dtsb_pkg::COL_W-1:0];
         end
         default: begin
            push_entry.ok  = 1'b1;
            push_entry.row = '0;
            push_entry.col = '0;
         end
      endcase
   end

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;
endmodule

// ===== src/dtsb_queue.sv =====
// Short queue between the classifying front end and the sample engine.
// Depends on dtsb_pkg.
module dtsb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dtsb_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output dtsb_pkg::entry_type  head
);
   localparam int CNT_W = $clog2(dtsb_pkg::QUEUE_DEPTH + 1);

   dtsb_pkg::entry_type             slot_ff [dtsb_pkg::QUEUE_DEPTH];
   logic [dtsb_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                count_ff, count_in;

   function automatic logic [dtsb_pkg::QPTR_W-1:0] bump(input logic [dtsb_pkg::QPTR_W-1:0] p);
      return (32'(p) == dtsb_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   assign full  = (32'(count_ff) == dtsb_pkg::QUEUE_DEPTH);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end
endmodule

// ===== src/dtsb_back.sv =====
// Sample engine: sample memory, clear sweep, depth test, resolve and dirty box.
// Depends on dtsb_pkg and dtsb_if.
module dtsb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  dtsb_pkg::entry_type  head,
   output logic                 pop,
   dtsb_rsp_if.source           rsp_chan
);
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CLEAR    = 8'b0000_0010,
      ST_FRAG_RD  = 8'b0000_0100,
      ST_FRAG_CMP = 8'b0000_1000,
      ST_RES_RD   = 8'b0001_0000,
      ST_RES_SUM  = 8'b0010_0000,
      ST_RES_DIV  = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   localparam int AW = dtsb_pkg::ADDR_W;
   localparam int BW = dtsb_pkg::BOX_W;

   state_type state_ff, state_in;
   dtsb_pkg::entry_type cur_ff, cur_in;

   logic [47:0]    mem [2**AW];
   logic [47:0]    rdata_ff;
   logic [AW-1:0]  rd_addr, wr_addr, frag_addr_ff, frag_addr_in;
   logic [47:0]    wr_data;
   logic           wr_en;

   logic [dtsb_pkg::CLR_W-1:0] clr_cnt_ff, clr_cnt_in, clr_total_ff, clr_total_in;
   logic [1:0]     i_ff, i_in, j_ff, j_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [11:0]    sum_r_ff, sum_g_ff, sum_b_ff, sum_r_in, sum_g_in, sum_b_in;

   logic signed [BW-1:0] left_ff, right_ff, low_ff, high_ff;
   logic signed [BW-1:0] left_in, right_in, low_in, high_in, cx_s, cy_s;
   logic [dtsb_pkg::CNT_W-1:0] total_ff, total_in;

   logic [7:0] r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic       acc_ff, acc_in;
   logic       out_free, last_tap;
   logic [dtsb_pkg::ROW_W-1:0] row;
   logic [dtsb_pkg::COL_W-1:0] col;

   logic        rv_ff, rv_in;
   logic [7:0]  or_ff, og_ff, ob_ff, or_in, og_in, ob_in;
   logic        oacc_ff, oacc_in;
   logic signed [BW-1:0] ol_ff, orr_ff, od_ff, ou_ff, ol_in, orr_in, od_in, ou_in;
   logic [dtsb_pkg::CNT_W-1:0] oc_ff, oc_in;

   // divide a channel sum by antialias squared, rounding down
   function automatic logic [7:0] div_sq(input logic [11:0] s, input logic [2:0] aa);
      logic [25:0] p;
      p = 26'(s) * 26'd7282;
      unique case (aa)
         3'd2:    return 8'(s >> 2);
         3'd3:    return p[23:16];
         3'd4:    return 8'(s >> 4);
         default: return s[7:0];
      endcase
   endfunction

   assign out_free = !rv_ff || rsp_chan.ready;
   assign row      = cur_ff.row + dtsb_pkg::ROW_W'(j_ff);
   assign col      = cur_ff.col + dtsb_pkg::COL_W'(i_ff);
   assign rd_addr  = AW'(32'(row) * 32'(cur_ff.grid.sw) + 32'(col));
   assign last_tap = ({1'b0, i_ff} == cur_ff.grid.aa - 3'd1)
                     && ({1'b0, j_ff} == cur_ff.grid.aa - 3'd1);
   assign cx_s     = BW'(cur_ff.col);
   assign cy_s     = BW'(cur_ff.row);

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = frag_addr_ff;
      wr_data = {cur_ff.depth, cur_ff.color};
      frag_addr_in = frag_addr_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_total_in = clr_total_ff;
      i_in = i_ff;
      j_in = j_ff;
      rd_vld_in = 1'b0;
      sum_r_in = sum_r_ff;
      sum_g_in = sum_g_ff;
      sum_b_in = sum_b_ff;
      left_in = left_ff;
      right_in = right_ff;
      low_in = low_ff;
      high_in = high_ff;
      total_in = total_ff;
      r_in = r_ff;
      g_in = g_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      rv_in = rv_ff && !rsp_chan.ready;
      or_in = or_ff;
      og_in = og_ff;
      ob_in = ob_ff;
      oacc_in = oacc_ff;
      ol_in = ol_ff;
      orr_in = orr_ff;
      od_in = od_ff;
      ou_in = ou_ff;
      oc_in = oc_ff;

      if (rd_vld_ff) begin
         sum_r_in = sum_r_ff + 12'(rdata_ff[23:16]);
         sum_g_in = sum_g_ff + 12'(rdata_ff[15:8]);
         sum_b_in = sum_b_ff + 12'(rdata_ff[7:0]);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               cur_in = head;
               i_in = '0;
               j_in = '0;
               sum_r_in = '0;
               sum_g_in = '0;
               sum_b_in = '0;
               r_in = '0;
               g_in = '0;
               b_in = '0;
               acc_in = 1'b0;
               clr_cnt_in = '0;
               clr_total_in = dtsb_pkg::CLR_W'(32'(head.grid.sw) * 32'(head.grid.sh));
               unique case (head.mode)
                  dtsb_pkg::MODE_CLEAR:    state_in = ST_CLEAR;
                  dtsb_pkg::MODE_FRAGMENT: state_in = head.ok ? ST_FRAG_RD : ST_DONE;
                  dtsb_pkg::MODE_RESOLVE:  state_in = head.ok ? ST_RES_RD : ST_DONE;
                  default:                 state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            // sweep every active sample, one entry a cycle
            if (clr_cnt_ff == clr_total_ff) begin
               left_in  = BW'(cur_ff.grid.sw);
               right_in = -1;
               low_in   = BW'(cur_ff.grid.sh);
               high_in  = -1;
               total_in = '0;
               state_in = ST_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = clr_cnt_ff[AW-1:0];
               wr_data = {24'd0, cur_ff.color};
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_FRAG_RD: begin
            frag_addr_in = rd_addr;
            state_in = ST_FRAG_CMP;
         end
         ST_FRAG_CMP: begin
            if (cur_ff.depth > rdata_ff[47:24]) begin
               wr_en = 1'b1;
               acc_in = 1'b1;
               if (cx_s < left_ff)  left_in  = cx_s;
               if (cx_s > right_ff) right_in = cx_s;
               if (cy_s < low_ff)   low_in   = cy_s;
               if (cy_s > high_ff)  high_in  = cy_s;
               if (total_ff != dtsb_pkg::COUNT_MAX) total_in = total_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_RES_RD: begin
            rd_vld_in = 1'b1;
            if (last_tap) begin
               state_in = ST_RES_SUM;
            end else if ({1'b0, i_ff} == cur_ff.grid.aa - 3'd1) begin
               i_in = '0;
               j_in = j_ff + 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_RES_SUM: state_in = ST_RES_DIV;
         ST_RES_DIV: begin
            r_in = div_sq(sum_r_ff, cur_ff.grid.aa);
            g_in = div_sq(sum_g_ff, cur_ff.grid.aa);
            b_in = div_sq(sum_b_ff, cur_ff.grid.aa);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free, then report
            if (out_free) begin
               rv_in = 1'b1;
               or_in = r_ff;
               og_in = g_ff;
               ob_in = b_ff;
               oacc_in = acc_ff;
               ol_in = left_ff;
               orr_in = right_ff;
               od_in = low_ff;
               ou_in = high_ff;
               oc_in = total_ff;
               if (cur_ff.mode == dtsb_pkg::MODE_READ_DIRTY) begin
                  left_in  = BW'(cur_ff.grid.sw);
                  right_in = -1;
                  low_in   = BW'(cur_ff.grid.sh);
                  high_in  = -1;
                  total_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         rv_ff     <= 1'b0;
         left_ff   <= BW'(1);
         right_ff  <= -1;
         low_ff    <= BW'(1);
         high_ff   <= -1;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         rv_ff     <= rv_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      frag_addr_ff <= frag_addr_in;
      clr_cnt_ff <= clr_cnt_in;
      clr_total_ff <= clr_total_in;
      i_ff <= i_in;
      j_ff <= j_in;
      sum_r_ff <= sum_r_in;
      sum_g_ff <= sum_g_in;
      sum_b_ff <= sum_b_in;
      r_ff <= r_in;
      g_ff <= g_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      or_ff <= or_in;
      og_ff <= og_in;
      ob_ff <= ob_in;
      oacc_ff <= oacc_in;
      ol_ff <= ol_in;
      orr_ff <= orr_in;
      od_ff <= od_in;
      ou_ff <= ou_in;
      oc_ff <= oc_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_chan.valid         = rv_ff;
   assign rsp_chan.red_out       = or_ff;
   assign rsp_chan.green_out     = og_ff;
   assign rsp_chan.blue_out      = ob_ff;
   assign rsp_chan.accepted      = oacc_ff;
   assign rsp_chan.box_left      = ol_ff;
   assign rsp_chan.box_right     = orr_ff;
   assign rsp_chan.box_down      = od_ff;
   assign rsp_chan.box_up        = ou_ff;
   assign rsp_chan.changed_count = oc_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_FRAG_CMP))
      else $error("sample memory written outside clear or depth test");

   a_clear_bound: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_CLEAR) |-> (clr_cnt_ff < clr_total_ff))
      else $error("clear sweep ran past the sample grid");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_FRAG_CMP) |=>
         (total_ff == dtsb_pkg::COUNT_MAX || total_ff == $past(total_ff) + 1'b1))
      else $error("dirty count did not advance on a stored fragment");
endmodule

// ===== src/depth_tested_sample_buffer.sv =====
// Top level of the depth-tested sample buffer: register file, front end, queue, engine.
// Depends on dtsb_pkg, dtsb_if, dtsb_front, dtsb_queue and dtsb_back.
//
//  channel    role     transaction
//  req_chan   sink     one command: clear, fragment, resolve or read-dirty
//  rsp_chan   source   one result per command, in order
//  csr_*      slave    APB-style register writes and reads, always ready
//
// A fragment passes through queue, address, registered read, depth test
// and result, bound by the read-then-write of one memory entry.
// A resolve makes one memory read per sample.
// A clear writes all sample_width * sample_height entries, one entry a cycle.
// Reset is synchronous; the sample memory is undefined until the first clear.
// A stalled response holds the engine; the two-entry queue keeps taking commands until full.
module depth_tested_sample_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   dtsb_req_if.sink                             req_chan,
   dtsb_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dtsb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   logic [8:0]  width_ff, height_ff;
   logic [2:0]  aa_ff;
   logic [23:0] bg_ff;
   logic        cfg_wr;
   logic [1:0]  reg_idx;
   logic [2:0]  aa_eff;
   logic [11:0] sw_raw, sh_raw;
   dtsb_pkg::grid_type grid;

   logic                q_full, q_empty, push, pop;
   dtsb_pkg::entry_type push_entry, head, push_mixed;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // take a register write at the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd1;
         height_ff <= 9'd1;
         aa_ff     <= 3'd1;
         bg_ff     <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            dtsb_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[8:0];
            dtsb_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[8:0];
            dtsb_pkg::REG_ANTIALIAS:    aa_ff     <= csr_pwdata[2:0];
            dtsb_pkg::REG_BACKGROUND:   bg_ff     <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dtsb_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         dtsb_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         dtsb_pkg::REG_ANTIALIAS:    csr_prdata = 32'(aa_ff);
         default:                    csr_prdata = 32'(bg_ff);
      endcase
   end

   // clamp antialias to one..four and saturate the sample extents
   always_comb begin
      if (aa_ff == 3'd0)     aa_eff = 3'd1;
      else if (aa_ff > 3'd4) aa_eff = 3'd4;
      else                   aa_eff = aa_ff;
      sw_raw = 12'(width_ff) * 12'(aa_eff);
      sh_raw = 12'(height_ff) * 12'(aa_eff);
      grid.aa = aa_eff;
      grid.sw = (32'(sw_raw) > dtsb_pkg::MAX_SAMPLE_WIDTH)
                ? dtsb_pkg::SW_W'(dtsb_pkg::MAX_SAMPLE_WIDTH) : dtsb_pkg::SW_W'(sw_raw);
      grid.sh = (32'(sh_raw) > dtsb_pkg::MAX_SAMPLE_HEIGHT)
                ? dtsb_pkg::SH_W'(dtsb_pkg::MAX_SAMPLE_HEIGHT) : dtsb_pkg::SH_W'(sh_raw);
   end

   // a clear carries the background colour in place of the fragment colour
   always_comb begin
      push_mixed = push_entry;
      if (push_entry.mode == dtsb_pkg::MODE_CLEAR) push_mixed.color = bg_ff;
   end

   dtsb_front u_front (
      .req_chan   (req_chan),
      .grid       (grid),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   dtsb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_mixed),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   dtsb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== tb/depth_tested_sample_buffer_tb.sv =====
// Self-checking testbench of depth_tested_sample_buffer: a scoreboard class predicts
// every result, plain tasks drive the request channel and the APB-style register port.
// Depends on dtsb_pkg, dtsb_if and the depth_tested_sample_buffer RTL.
`timescale 1ns / 100ps

module depth_tested_sample_buffer_tb;

   localparam int CLOCK_HIGH  = 10;
   localparam int CLOCK_LOW   = 10;
   localparam int IDLE_LIMIT  = 300000;   // longest clear walks all 65536 samples
   localparam int ITEMS_PHASE = 115;
   localparam int HOLD_CYCLES = 400;
   localparam int GRID_CELLS  = dtsb_pkg::MAX_SAMPLE_WIDTH * dtsb_pkg::MAX_SAMPLE_HEIGHT;

   // one command as offered on the request channel
   typedef struct {
      dtsb_pkg::mode_type mode;
      int                 x;
      int                 y;
      logic [23:0]        depth;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } command_type;

   // one result as seen on the response channel
   typedef struct {
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
      logic                       hit;
      logic [dtsb_pkg::BOX_W-1:0] left;
      logic [dtsb_pkg::BOX_W-1:0] right;
      logic [dtsb_pkg::BOX_W-1:0] down;
      logic [dtsb_pkg::BOX_W-1:0] up;
      logic [dtsb_pkg::CNT_W-1:0] count;
   } pixel_result_type;

   // ------------------------------------------------------------------
   // Scoreboard: shadow copy of the sample stores, dirty box and registers
   // ------------------------------------------------------------------
   class sample_buffer_scoreboard;
      logic [23:0]      depth_mem [GRID_CELLS];
      logic [23:0]      color_mem [GRID_CELLS];
      int               width_reg, height_reg, aa_reg;
      logic [23:0]      background_reg;
      int               left_edge, right_edge, low_edge, high_edge, dirty_tally;
      pixel_result_type awaited [$];
      int               errors;

      function new();
         width_reg = 1;
         height_reg = 1;
         aa_reg = 1;
         background_reg = '0;
         errors = 0;
         empty_box();
      endfunction

      function int eff_aa();
         if (aa_reg < 1) return 1;
         if (aa_reg > 4) return 4;
         return aa_reg;
      endfunction

      function int sample_w();
         int w;
         w = width_reg * eff_aa();
         return (w > dtsb_pkg::MAX_SAMPLE_WIDTH) ? dtsb_pkg::MAX_SAMPLE_WIDTH : w;
      endfunction

      function int sample_h();
         int h;
         h = height_reg * eff_aa();
         return (h > dtsb_pkg::MAX_SAMPLE_HEIGHT) ? dtsb_pkg::MAX_SAMPLE_HEIGHT : h;
      endfunction

      function void empty_box();
         left_edge = sample_w();
         right_edge = -1;
         low_edge = sample_h();
         high_edge = -1;
         dirty_tally = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            dtsb_pkg::REG_IMAGE_WIDTH:  width_reg = int'(value[8:0]);
            dtsb_pkg::REG_IMAGE_HEIGHT: height_reg = int'(value[8:0]);
            dtsb_pkg::REG_ANTIALIAS:    aa_reg = int'(value[2:0]);
            dtsb_pkg::REG_BACKGROUND:   background_reg = value[23:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // note an accepted command and queue the result it must produce
      function void note_command(command_type c);
         pixel_result_type res;
         int sw, sh, aa, idx, sr, sg, sb;
         sw = sample_w();
         sh = sample_h();
         aa = eff_aa();
         res = '{default: '0};
         case (c.mode)
            dtsb_pkg::MODE_CLEAR: begin
               for (int y = 0; y < sh; y++)
                  for (int x = 0; x < sw; x++) begin
                     depth_mem[y*sw+x] = '0;
                     color_mem[y*sw+x] = background_reg;
                  end
               empty_box();
            end
            dtsb_pkg::MODE_FRAGMENT: begin
               if (c.x >= 0 && c.x < sw && c.y >= 0 && c.y < sh
                   && c.depth > dtsb_pkg::DEPTH_ONE) begin
                  idx = c.y * sw + c.x;
                  if (c.depth > depth_mem[idx]) begin
                     depth_mem[idx] = c.depth;
                     color_mem[idx] = {c.red, c.green, c.blue};
                     if (c.x < left_edge)  left_edge = c.x;
                     if (c.x > right_edge) right_edge = c.x;
                     if (c.y < low_edge)   low_edge = c.y;
                     if (c.y > high_edge)  high_edge = c.y;
                     if (dirty_tally < int'(dtsb_pkg::COUNT_MAX)) dirty_tally++;
                     res.hit = 1'b1;
                  end
               end
            end
            dtsb_pkg::MODE_RESOLVE: begin
               if (c.x >= 0 && c.y >= 0 && (c.x + 1) * aa <= sw && (c.y + 1) * aa <= sh) begin
                  sr = 0; sg = 0; sb = 0;
                  for (int j = 0; j < aa; j++)
                     for (int i = 0; i < aa; i++) begin
                        idx = (c.y * aa + j) * sw + (c.x * aa + i);
                        sr += color_mem[idx][23:16];
                        sg += color_mem[idx][15:8];
                        sb += color_mem[idx][7:0];
                     end
                  res.red   = 8'(sr / (aa * aa));
                  res.green = 8'(sg / (aa * aa));
                  res.blue  = 8'(sb / (aa * aa));
               end
            end
            default: ;
         endcase
         res.left  = dtsb_pkg::BOX_W'(left_edge);
         res.right = dtsb_pkg::BOX_W'(right_edge);
         res.down  = dtsb_pkg::BOX_W'(low_edge);
         res.up    = dtsb_pkg::BOX_W'(high_edge);
         res.count = dtsb_pkg::CNT_W'(dirty_tally);
         if (c.mode == dtsb_pkg::MODE_READ_DIRTY) empty_box();
         awaited.push_back(res);
      endfunction

      task report_mismatch(string field, longint got, longint want);
         $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
         errors++;
      endtask

      // check one result against the oldest expectation
      task check_result(pixel_result_type got);
         pixel_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with no command outstanding", $realtime);
            errors++;
         end else begin
            want = awaited.pop_front();
            if (got.red   !== want.red)   report_mismatch("red_out", got.red, want.red);
            if (got.green !== want.green) report_mismatch("green_out", got.green, want.green);
            if (got.blue  !== want.blue)  report_mismatch("blue_out", got.blue, want.blue);
            if (got.hit   !== want.hit)   report_mismatch("accepted", got.hit, want.hit);
            if (got.left  !== want.left)  report_mismatch("box_left", got.left, want.left);
            if (got.right !== want.right) report_mismatch("box_right", got.right, want.right);
            if (got.down  !== want.down)  report_mismatch("box_down", got.down, want.down);
            if (got.up    !== want.up)    report_mismatch("box_up", got.up, want.up);
            if (got.count !== want.count)
               report_mismatch("changed_count", got.count, want.count);
         end
      endtask
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block itself
   // ------------------------------------------------------------------
   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dtsb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   dtsb_req_if req_chan ();
   dtsb_rsp_if rsp_chan ();

   sample_buffer_scoreboard board;

   int tx_idle_pct;      // chance per try that the sender idles before offering an item
   int rx_idle_pct;      // chance per cycle that the receiver drops ready
   int hold_request;     // raised by the stimulus, taken by the receiver process
   int hold_left;
   int quiet_cycles;

   depth_tested_sample_buffer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #CLOCK_HIGH;
      clock = 1'b0;
      #CLOCK_LOW;
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   // The hold is counted here so the stimulus keeps offering commands meanwhile.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Check every response transaction against the oldest expectation.
   always @(posedge clock) begin
      pixel_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.red   = rsp_chan.red_out;
         got.green = rsp_chan.green_out;
         got.blue  = rsp_chan.blue_out;
         got.hit   = rsp_chan.accepted;
         got.left  = rsp_chan.box_left;
         got.right = rsp_chan.box_right;
         got.down  = rsp_chan.box_down;
         got.up    = rsp_chan.box_up;
         got.count = rsp_chan.changed_count;
         board.check_result(got);
      end
   end

   // Watchdog: end the run once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_psel) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL depth_tested_sample_buffer");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driving tasks
   // ------------------------------------------------------------------

   // APB-style write: setup cycle, then access cycle; pready is always high
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // offer one command, idling at random first; valid stays high on return
   task automatic send_command(command_type c);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= c.mode;
      req_chan.coord_x  <= 13'(c.x);
      req_chan.coord_y  <= 13'(c.y);
      req_chan.depth    <= c.depth;
      req_chan.red_in   <= c.red;
      req_chan.green_in <= c.green;
      req_chan.blue_in  <= c.blue;
      do @(posedge clock); while (!req_chan.ready);
      board.note_command(c);
   endtask

   task automatic send(dtsb_pkg::mode_type m, int x, int y, logic [23:0] d,
                       logic [7:0] r = 8'h5a, logic [7:0] g = 8'ha5, logic [7:0] b = 8'h3c);
      command_type c;
      c = '{mode: m, x: x, y: y, depth: d, red: r, green: g, blue: b};
      send_command(c);
   endtask

   // drop valid and wait until every result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic int any_coord();
      logic [12:0] v;
      v = 13'($urandom);
      return int'($signed(v));
   endfunction

   // Mostly well-formed traffic inside the grid; the rest is noise.
   // Clears are only drawn on small grids, since one clear walks every sample.
   function automatic command_type random_command();
      command_type c;
      int sw, sh, aa, roll;
      sw = board.sample_w();
      sh = board.sample_h();
      aa = board.eff_aa();
      c.depth = 24'($urandom);
      c.red   = 8'($urandom);
      c.green = 8'($urandom);
      c.blue  = 8'($urandom);
      c.x = any_coord();
      c.y = any_coord();
      roll = $urandom_range(99);
      if (roll < 55 || (roll >= 85 && roll < 90 && sw * sh > 4096)) begin
         c.mode = dtsb_pkg::MODE_FRAGMENT;
         if ($urandom_range(99) < 85 && sw > 0 && sh > 0) begin
            c.x = $urandom_range(sw - 1);
            c.y = $urandom_range(sh - 1);
         end
         if ($urandom_range(99) < 10) c.depth = 24'($urandom_range(300));
      end else if (roll < 75) begin
         c.mode = dtsb_pkg::MODE_RESOLVE;
         if ($urandom_range(99) < 85) begin
            c.x = $urandom_range(sw / aa);
            c.y = $urandom_range(sh / aa);
         end
      end else if (roll < 85) begin
         c.mode = dtsb_pkg::MODE_READ_DIRTY;
      end else if (roll < 90) begin
         c.mode = dtsb_pkg::MODE_CLEAR;
      end else begin
         // noise: any mode but clear, coordinates anywhere
         c.mode = dtsb_pkg::mode_type'($urandom_range(3, 1));
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   // grid settings per phase: width, height, antialias
   int phase_w  [6] = '{3, 256, 0, 5, 100, 1};
   int phase_h  [6] = '{2, 256, 5, 4, 3,   1};
   int phase_aa [6] = '{2, 4,   0, 7, 3,   1};

   initial begin
      board = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = dtsb_pkg::MODE_CLEAR;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.depth = '0;
      req_chan.red_in = '0;
      req_chan.green_in = '0;
      req_chan.blue_in = '0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tx_idle_pct = 22;
      rx_idle_pct = 84;
      hold_request = 0;
      hold_left = 0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < 6; p++) begin
         // idling: sender light / receiver heavy, then swapped, then none
         tx_idle_pct = (p < 2) ? 22 : (p < 4) ? 84 : 0;
         rx_idle_pct = (p < 2) ? 84 : (p < 4) ? 22 : 0;
         write_register(dtsb_pkg::REG_IMAGE_WIDTH, 32'(phase_w[p]));
         write_register(dtsb_pkg::REG_IMAGE_HEIGHT, 32'(phase_h[p]));
         write_register(dtsb_pkg::REG_ANTIALIAS, 32'(phase_aa[p]));
         write_register(dtsb_pkg::REG_BACKGROUND,
                        (p == 1) ? 32'hffffff : (p == 5) ? 32'h0 : $urandom);
         // every phase starts from a cleared store so no unwritten entry is ever read
         send(dtsb_pkg::MODE_CLEAR, 0, 0, '0);

         if (p == 0) begin
            // 6x4 sample grid: bounds, the 1.0 depth floor, depth order, resolve edges
            send(dtsb_pkg::MODE_FRAGMENT, 0, 0, 24'd257, 8'hff, 8'hff, 8'hff);
            send(dtsb_pkg::MODE_FRAGMENT, 1, 0, dtsb_pkg::DEPTH_ONE);
            send(dtsb_pkg::MODE_FRAGMENT, 5, 3, 24'hffffff, 8'h00, 8'h00, 8'h00);
            send(dtsb_pkg::MODE_FRAGMENT, 5, 3, 24'd300);
            send(dtsb_pkg::MODE_FRAGMENT, -4096, 0, 24'h1000);
            send(dtsb_pkg::MODE_FRAGMENT, 4095, 4095, 24'h1000);
            send(dtsb_pkg::MODE_FRAGMENT, 6, 0, 24'h1000);
            send(dtsb_pkg::MODE_FRAGMENT, 0, -1, 24'h1000);
            send(dtsb_pkg::MODE_FRAGMENT, 1, 1, 24'h2000, 8'h00, 8'h00, 8'h00);
            send(dtsb_pkg::MODE_FRAGMENT, 0, 1, 24'h2000, 8'hff, 8'hff, 8'hff);
            send(dtsb_pkg::MODE_RESOLVE, 0, 0, '0);
            send(dtsb_pkg::MODE_RESOLVE, 2, 1, '0);
            send(dtsb_pkg::MODE_RESOLVE, 3, 0, '0);
            send(dtsb_pkg::MODE_RESOLVE, -1, 0, '0);
            send(dtsb_pkg::MODE_RESOLVE, -4096, 4095, '0);
            send(dtsb_pkg::MODE_READ_DIRTY, 0, 0, '0);
            send(dtsb_pkg::MODE_READ_DIRTY, 0, 0, '0);
         end

         for (int n = 0; n < ITEMS_PHASE; n++) begin
            // stall the receiver for a long stretch so the queue fills and backs up
            if (p == 3 && n == 20) hold_request = 1;
            send_command(random_command());
         end

         drain();
      end

      if (board.errors == 0) begin
         $display("PASS depth_tested_sample_buffer");
      end else begin
         $display("FAIL depth_tested_sample_buffer");
      end
      $finish;
   end

endmodule
